FILE: hw/rtl/gripper_pd_force_controller_top_assert.svh
// Assertion macros shared by the gripper force controller RTL.
`ifndef GRIPPER_PD_FORCE_CONTROLLER_TOP_ASSERT_SVH
`define GRIPPER_PD_FORCE_CONTROLLER_TOP_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define GPFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GPFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/gpfc_pkg.sv
`default_nettype none

package gpfc_pkg;

   localparam int FIELD_W    = 32;
   localparam int LIMIT_W    = 31;
   localparam int GRIP_W     = 31;
   localparam int GAIN_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // internal widths, each large enough that nothing wraps
   localparam int W_SUM    = FIELD_W + 2;
   localparam int W_PP     = W_SUM + FRAC_W + 1;
   localparam int W_TERM   = W_PP + 1;
   localparam int W_CD     = W_TERM + 1;
   localparam int W_LR     = W_CD + 1;
   localparam int GRIP_X_W = LIMIT_W + 1;

   localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT_RST = LIMIT_W'(65536);

   localparam int NUM_STAGES = 7;
   localparam int STG_IN     = 0;
   localparam int STG_PP     = 1;
   localparam int STG_TERM   = 2;
   localparam int STG_SUM    = 3;
   localparam int STG_CLAMP  = 4;
   localparam int STG_COMB   = 5;
   localparam int STG_OUT    = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CMD_STIFF  = 3'd0,
      CSR_CMD_DAMP   = 3'd1,
      CSR_CON_STIFF  = 3'd2,
      CSR_CON_DAMP   = 3'd3,
      CSR_DEF_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] valid;
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

   function automatic logic signed [W_SUM-1:0] sext_sum(input logic signed [FIELD_W-1:0] x);
      sext_sum = W_SUM'(x);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gripper_pd_force_controller_top.sv
// Channel  Ports        Direction  Beat contents
// req      req_valid    in         sample: setpoints, finger states, optional limit
// rsp      rsp_valid    out        left, right and squeeze forces
// csr      csr_wr_en    in         register write, no handshake back
//
// One beat per cycle in each direction while nothing stalls; rsp_valid rises as a beat
// reaches the last of seven register stages, the first loaded at the accepting edge: sums,
// gain partial products, product merge, PD sums, clamp and halving, combine, saturation.
// reset is synchronous and clears the stage valids and the gain registers, not the data path.
// A stall on rsp holds each full stage with no empty stage after it; empty stages keep filling,
// so req_stall rises only once the pipe in front of a held output is full.
`default_nettype none

module gripper_pd_force_controller_top #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [gpfc_pkg::FIELD_W-1:0]   req_desired_separation,
   input  logic signed [gpfc_pkg::FIELD_W-1:0]   req_desired_rate,
   input  logic signed [gpfc_pkg::FIELD_W-1:0]   req_left_position,
   input  logic signed [gpfc_pkg::FIELD_W-1:0]   req_right_position,
   input  logic signed [gpfc_pkg::FIELD_W-1:0]   req_left_velocity,
   input  logic signed [gpfc_pkg::FIELD_W-1:0]   req_right_velocity,
   input  logic                                  req_limit_present,
   input  logic [gpfc_pkg::LIMIT_W-1:0]          req_limit_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [gpfc_pkg::FIELD_W-1:0]   rsp_left_force,
   output logic signed [gpfc_pkg::FIELD_W-1:0]   rsp_right_force,
   output logic [gpfc_pkg::GRIP_W-1:0]           rsp_squeeze_force,
   input  logic                                  csr_wr_en,
   input  logic [gpfc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gpfc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gpfc_pkg::*;

   pipe_ctl_type ctl;

   logic [GAIN_W-1:0]  cmd_stiff_ff, cmd_stiff_in;
   logic [GAIN_W-1:0]  cmd_damp_ff, cmd_damp_in;
   logic [GAIN_W-1:0]  con_stiff_ff, con_stiff_in;
   logic [GAIN_W-1:0]  con_damp_ff, con_damp_in;
   logic [LIMIT_W-1:0] def_limit_ff, def_limit_in;

   logic signed [W_SUM-1:0] pos_sum_in, pos_sum_ff;
   logic signed [W_SUM-1:0] vel_sum_in, vel_sum_ff;
   logic signed [W_SUM-1:0] sep_err_in, sep_err_ff;
   logic signed [W_SUM-1:0] rate_err_in, rate_err_ff;
   logic [LIMIT_W-1:0]      lim0_in, lim0_ff, lim1_ff, lim2_ff;

   logic signed [W_TERM-1:0] t_con_stiff, t_con_damp, t_cmd_stiff, t_cmd_damp;

   always_comb begin
      cmd_stiff_in = cmd_stiff_ff;
      cmd_damp_in  = cmd_damp_ff;
      con_stiff_in = con_stiff_ff;
      con_damp_in  = con_damp_ff;
      def_limit_in = def_limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CMD_STIFF: cmd_stiff_in = csr_wdata[GAIN_W-1:0];
            CSR_CMD_DAMP:  cmd_damp_in  = csr_wdata[GAIN_W-1:0];
            CSR_CON_STIFF: con_stiff_in = csr_wdata[GAIN_W-1:0];
            CSR_CON_DAMP:  con_damp_in  = csr_wdata[GAIN_W-1:0];
            CSR_DEF_LIMIT: def_limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_stiff_ff <= '0;
         cmd_damp_ff  <= '0;
         con_stiff_ff <= '0;
         con_damp_ff  <= '0;
         def_limit_ff <= DEFAULT_LIMIT_RST;
      end else begin
         cmd_stiff_ff <= cmd_stiff_in;
         cmd_damp_ff  <= cmd_damp_in;
         con_stiff_ff <= con_stiff_in;
         con_damp_ff  <= con_damp_in;
         def_limit_ff <= def_limit_in;
      end
   end

   gpfc_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   assign pos_sum_in  = sext_sum(req_left_position) + sext_sum(req_right_position);
   assign vel_sum_in  = sext_sum(req_left_velocity) + sext_sum(req_right_velocity);
   assign sep_err_in  = sext_sum(req_desired_separation) + sext_sum(req_left_position)
                        - sext_sum(req_right_position);
   assign rate_err_in = sext_sum(req_desired_rate) + sext_sum(req_left_velocity)
                        - sext_sum(req_right_velocity);
   assign lim0_in     = req_limit_present ? req_limit_value : def_limit_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[STG_IN]) begin
         pos_sum_ff  <= pos_sum_in;
         vel_sum_ff  <= vel_sum_in;
         sep_err_ff  <= sep_err_in;
         rate_err_ff <= rate_err_in;
         lim0_ff     <= lim0_in;
      end
      if (ctl.load[STG_PP]) begin
         lim1_ff <= lim0_ff;
      end
      if (ctl.load[STG_TERM]) begin
         lim2_ff <= lim1_ff;
      end
   end

   gpfc_gain_mul u_mul_con_stiff (
      .clock   (clock),
      .ctl     (ctl),
      .gain    (con_stiff_ff),
      .operand (pos_sum_ff),
      .term    (t_con_stiff)
   );

   gpfc_gain_mul u_mul_con_damp (
      .clock   (clock),
      .ctl     (ctl),
      .gain    (con_damp_ff),
      .operand (vel_sum_ff),
      .term    (t_con_damp)
   );

   gpfc_gain_mul u_mul_cmd_stiff (
      .clock   (clock),
      .ctl     (ctl),
      .gain    (cmd_stiff_ff),
      .operand (sep_err_ff),
      .term    (t_cmd_stiff)
   );

   gpfc_gain_mul u_mul_cmd_damp (
      .clock   (clock),
      .ctl     (ctl),
      .gain    (cmd_damp_ff),
      .operand (rate_err_ff),
      .term    (t_cmd_damp)
   );

   gpfc_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .t_con_stiff   (t_con_stiff),
      .t_con_damp    (t_con_damp),
      .t_cmd_stiff   (t_cmd_stiff),
      .t_cmd_damp    (t_cmd_damp),
      .limit         (lim2_ff),
      .left_force    (rsp_left_force),
      .right_force   (rsp_right_force),
      .squeeze_force (rsp_squeeze_force)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/gpfc_pipe_ctl.sv
`default_nettype none
`include "gripper_pd_force_controller_top_assert.svh"

module gpfc_pipe_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gpfc_pkg::pipe_ctl_type ctl
);
   import gpfc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;
   logic                  acc_beat;
   logic                  del_beat;

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign ctl.valid = valid_ff;
   assign ctl.load  = load;
   assign acc_beat  = req_valid && load[0];
   assign del_beat  = valid_ff[NUM_STAGES-1] && !rsp_stall;

   `GPFC_ASSERT(a_full_stall, clock, reset, ((&valid_ff) && rsp_stall) |-> req_stall, "pipe full and stalled but input not stalled")
   `GPFC_ASSERT_NEXT(a_accept_enters, clock, reset, acc_beat, valid_ff[STG_IN], "accepted beat missing from first stage")
   `GPFC_ASSERT_NEXT(a_count, clock, reset, 1'b1, $countones(valid_ff) == $past($countones(valid_ff)) + $past(acc_beat) - $past(del_beat), "beats lost or duplicated in pipe")

endmodule

`default_nettype wire

FILE: hw/rtl/gpfc_gain_mul.sv
`default_nettype none

module gpfc_gain_mul (
   input  logic                                  clock,
   input  gpfc_pkg::pipe_ctl_type                ctl,
   input  logic [gpfc_pkg::GAIN_W-1:0]           gain,
   input  logic signed [gpfc_pkg::W_SUM-1:0]     operand,
   output logic signed [gpfc_pkg::W_TERM-1:0]    term
);
   import gpfc_pkg::*;

   logic signed [FRAC_W:0]   gain_hi;
   logic signed [FRAC_W:0]   gain_lo;
   logic signed [W_PP-1:0]   pp_hi_in;
   logic signed [W_PP-1:0]   pp_lo_in;
   logic signed [W_PP-1:0]   pp_hi_ff;
   logic signed [W_PP-1:0]   pp_lo_ff;
   logic signed [W_PP-1:0]   pp_lo_sh;
   logic signed [W_TERM-1:0] term_in;
   logic signed [W_TERM-1:0] term_ff;

   // floor(gain * x / 2^16) = hi * x + floor(lo * x / 2^16)
   assign gain_hi  = $signed({1'b0, gain[GAIN_W-1:FRAC_W]});
   assign gain_lo  = $signed({1'b0, gain[FRAC_W-1:0]});
   assign pp_hi_in = gain_hi * operand;
   assign pp_lo_in = gain_lo * operand;
   assign pp_lo_sh = pp_lo_ff >>> FRAC_W;
   assign term_in  = W_TERM'(pp_hi_ff) + W_TERM'(pp_lo_sh);

   always_ff @(posedge clock) begin
      if (ctl.load[STG_PP]) begin
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
      end
      if (ctl.load[STG_TERM]) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/gpfc_out.sv
`default_nettype none
`include "gripper_pd_force_controller_top_assert.svh"

module gpfc_out #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gpfc_pkg::pipe_ctl_type                ctl,
   input  logic signed [gpfc_pkg::W_TERM-1:0]    t_con_stiff,
   input  logic signed [gpfc_pkg::W_TERM-1:0]    t_con_damp,
   input  logic signed [gpfc_pkg::W_TERM-1:0]    t_cmd_stiff,
   input  logic signed [gpfc_pkg::W_TERM-1:0]    t_cmd_damp,
   input  logic [gpfc_pkg::LIMIT_W-1:0]          limit,
   output logic signed [gpfc_pkg::FIELD_W-1:0]   left_force,
   output logic signed [gpfc_pkg::FIELD_W-1:0]   right_force,
   output logic [gpfc_pkg::GRIP_W-1:0]           squeeze_force
);
   import gpfc_pkg::*;

   localparam int SAT_W = 66;
   localparam logic signed [SAT_W-1:0] SMAX = (SAT_W'(1) <<< (DATA_WIDTH - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] SMIN = ~SMAX;

   logic signed [W_CD-1:0]     common3_in, common3_ff;
   logic signed [W_CD-1:0]     diff3_in, diff3_ff;
   logic [LIMIT_W-1:0]         lim3_ff;
   logic signed [W_CD-1:0]     lim_x, lim_neg, diff_c;
   logic signed [W_CD-1:0]     hc4_in, hc4_ff, hd4_in, hd4_ff;
   logic signed [W_CD-1:0]     hd_mag;
   logic signed [W_LR-1:0]     left5_in, left5_ff, right5_in, right5_ff;
   logic [GRIP_X_W-1:0]        grip5_in, grip5_ff;
   logic signed [W_LR-1:0]     grip5_chk;
   logic signed [SAT_W-1:0]    left_x, right_x, grip_x;
   logic signed [SAT_W-1:0]    left_s, right_s, grip_s;
   logic signed [FIELD_W-1:0]  left6_in, left6_ff, right6_in, right6_ff;
   logic [GRIP_W-1:0]          grip6_in, grip6_ff;

   assign common3_in = -W_CD'(t_con_stiff) - W_CD'(t_con_damp);
   assign diff3_in   = W_CD'(t_cmd_stiff) + W_CD'(t_cmd_damp);

   assign lim_x   = $signed(W_CD'(lim3_ff));
   assign lim_neg = -lim_x;

   always_comb begin
      priority if (diff3_ff > lim_x) begin
         diff_c = lim_x;
      end else if (diff3_ff < lim_neg) begin
         diff_c = lim_neg;
      end else begin
         diff_c = diff3_ff;
      end
   end

   assign hd4_in = diff_c >>> 1;
   assign hc4_in = common3_ff >>> 1;

   assign left5_in  = W_LR'(hc4_ff) - W_LR'(hd4_ff);
   assign right5_in = W_LR'(hc4_ff) + W_LR'(hd4_ff);
   assign hd_mag    = hd4_ff[W_CD-1] ? -hd4_ff : hd4_ff;
   assign grip5_in  = {hd_mag[LIMIT_W-1:0], 1'b0};

   assign left_x  = SAT_W'(left5_ff);
   assign right_x = SAT_W'(right5_ff);
   assign grip_x  = $signed(SAT_W'(grip5_ff));
   assign left_s  = (left_x > SMAX) ? SMAX : ((left_x < SMIN) ? SMIN : left_x);
   assign right_s = (right_x > SMAX) ? SMAX : ((right_x < SMIN) ? SMIN : right_x);
   assign grip_s  = (grip_x > SMAX) ? SMAX : grip_x;
   assign left6_in  = left_s[FIELD_W-1:0];
   assign right6_in = right_s[FIELD_W-1:0];
   assign grip6_in  = grip_s[GRIP_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load[STG_SUM]) begin
         common3_ff <= common3_in;
         diff3_ff   <= diff3_in;
         lim3_ff    <= limit;
      end
      if (ctl.load[STG_CLAMP]) begin
         hc4_ff <= hc4_in;
         hd4_ff <= hd4_in;
      end
      if (ctl.load[STG_COMB]) begin
         left5_ff  <= left5_in;
         right5_ff <= right5_in;
         grip5_ff  <= grip5_in;
      end
      if (ctl.load[STG_OUT]) begin
         left6_ff  <= left6_in;
         right6_ff <= right6_in;
         grip6_ff  <= grip6_in;
      end
   end

   assign left_force    = left6_ff;
   assign right_force   = right6_ff;
   assign squeeze_force = grip6_ff;

   assign grip5_chk = $signed(W_LR'(grip5_ff));

   `GPFC_ASSERT(a_hd_bound, clock, reset, ctl.valid[STG_CLAMP] |-> ((&hd4_ff[W_CD-1:LIMIT_W-1]) || !(|hd4_ff[W_CD-1:LIMIT_W-1])), "half difference exceeds limit range")
   `GPFC_ASSERT(a_grip_diff, clock, reset, ctl.valid[STG_COMB] |-> (((right5_ff - left5_ff) == grip5_chk) || ((left5_ff - right5_ff) == grip5_chk)), "grip is not the force difference")
   `GPFC_ASSERT_NEXT(a_grip_zero, clock, reset, ctl.valid[STG_CLAMP] && ctl.load[STG_COMB] && (hd4_ff == '0), grip5_ff == '0, "zero difference gave nonzero grip")

endmodule

`default_nettype wire
